[rtl/core/tcld_pkg.sv]
// Shared types, codes and keyword tables for the text command line decoder.
// No dependencies; the scanner, decoder and top level import this package.
`timescale 1ns / 1ps
`default_nettype none

package tcld_pkg;

    localparam int LINE_CAPACITY_DEF = 96;
    localparam int MAX_FIELDS_DEF    = 4;
    localparam int ATT_MAX_RESET     = 63;
    localparam int NUM_INT_MAX       = 32767;
    localparam int PHASE_MAX         = 675;
    localparam int PHASE_STEP        = 45;
    localparam int PHASE_CODES       = PHASE_MAX / PHASE_STEP + 1;

    localparam int KW_COUNT  = 17;
    localparam int KW_MAXLEN = 9;

    localparam int KW_PING      = 0;
    localparam int KW_KEEPALIVE = 1;
    localparam int KW_HELP      = 2;
    localparam int KW_STATUS    = 3;
    localparam int KW_SAFE      = 4;
    localparam int KW_FAULT     = 5;
    localparam int KW_CLEAR     = 6;
    localparam int KW_POWER     = 7;
    localparam int KW_EXTERNAL  = 8;
    localparam int KW_ON        = 9;
    localparam int KW_OFF       = 10;
    localparam int KW_ATT       = 11;
    localparam int KW_PHASE     = 12;
    localparam int KW_LNA       = 13;
    localparam int KW_ONE       = 14;
    localparam int KW_TWO       = 15;
    localparam int KW_ALL       = 16;

    localparam logic [KW_MAXLEN*8-1:0] KW_STR [KW_COUNT] = '{
        "PING", "KEEPALIVE", "HELP", "STATUS", "SAFE", "FAULT", "CLEAR",
        "POWER", "EXTERNAL", "ON", "OFF", "ATT", "PHASE", "LNA", "1", "2", "ALL"
    };
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd4, 4'd9, 4'd4, 4'd6, 4'd4, 4'd5, 4'd5, 4'd5, 4'd8, 4'd2, 4'd3,
        4'd3, 4'd5, 4'd3, 4'd1, 4'd1, 4'd3
    };

    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_TAB   = 8'h09;
    localparam logic [7:0] CHR_DOT   = 8'h2e;
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_FIVE  = 8'h35;
    localparam logic [7:0] CHR_NINE  = 8'h39;

    typedef logic [KW_COUNT-1:0] t_kw_vec;

    typedef enum logic [3:0] {
        CMD_NONE      = 4'd0,
        CMD_PING      = 4'd1,
        CMD_KEEPALIVE = 4'd2,
        CMD_HELP      = 4'd3,
        CMD_STATUS    = 4'd4,
        CMD_SAFE      = 4'd5,
        CMD_FAULT_CLR = 4'd6,
        CMD_POWER     = 4'd7,
        CMD_POWER_EXT = 4'd8,
        CMD_ATT       = 4'd9,
        CMD_PHASE     = 4'd10,
        CMD_LNA       = 4'd11
    } t_command;

    typedef enum logic [2:0] {
        ERR_OK       = 3'd0,
        ERR_EMPTY    = 3'd1,
        ERR_TOO_LONG = 3'd2,
        ERR_SYNTAX   = 3'd3,
        ERR_RANGE    = 3'd4
    } t_error;

    typedef enum logic [2:0] {
        NUM_NODIGIT = 3'd0,
        NUM_INT     = 3'd1,
        NUM_DOT     = 3'd2,
        NUM_FRAC    = 3'd3,
        NUM_BAD     = 3'd4
    } t_num_phase;

    localparam logic [3:0] REG_ATT_MAX = 4'd0;

    typedef struct packed {
        logic        too_long;
        logic [3:0]  nfields;
        t_kw_vec     match0;
        t_kw_vec     match1;
        t_kw_vec     match2;
        logic        num_ok;
        logic [15:0] num;
    } t_line_sum;

    typedef struct packed {
        t_command   command;
        t_error     error_code;
        logic [1:0] chan_sel;
        logic [7:0] amount;
        logic       switch_on;
    } t_result;

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        logic [7:0] r;
        begin
            r = ((c >= 8'h61) && (c <= 8'h7a)) ? (c - 8'd32) : c;
            return r;
        end
    endfunction

    function automatic logic kw_hit(input int k, input logic [3:0] idx,
                                    input logic [7:0] c);
        int pos;
        begin
            pos = int'(KW_LEN[k]) - 1 - int'(idx);
            if (pos < 0) begin
                pos = 0;
            end
            return (int'(idx) < int'(KW_LEN[k])) && (KW_STR[k][pos*8 +: 8] == c);
        end
    endfunction

endpackage

`default_nettype wire

[rtl/core/tcld_ifs.sv]
// Handshake channel interfaces for the command line decoder.
// Depends on nothing; the payload widths follow the item fields.
`timescale 1ns / 1ps
`default_nettype none

interface tcld_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       line_end;
    modport source(output valid, output text_byte, output line_end, input ready);
    modport sink(input valid, input text_byte, input line_end, output ready);
endinterface

interface tcld_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] command;
    logic [2:0] error_code;
    logic [1:0] chan_sel;
    logic [7:0] amount;
    logic       switch_on;
    modport source(output valid, output command, output error_code,
                   output chan_sel, output amount, output switch_on, input ready);
    modport sink(input valid, input command, input error_code,
                 input chan_sel, input amount, input switch_on, output ready);
endinterface

`default_nettype wire

[rtl/core/tcld_scan.sv]
// Per-character line scanner: field splitting, keyword matching and number parsing.
// Depends on tcld_pkg; produces a line summary for the decode stage.
`timescale 1ns / 1ps
`default_nettype none

module tcld_scan
    import tcld_pkg::*;
#(
    parameter int LINE_CAPACITY = LINE_CAPACITY_DEF,
    parameter int MAX_FIELDS    = MAX_FIELDS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_text_byte,
    input  wire logic       i_line_end,
    output t_line_sum       o_sum
);

    localparam int LEN_W = $clog2(LINE_CAPACITY + 1);
    localparam int FC_W  = $clog2(MAX_FIELDS + 2);
    localparam logic [3:0] IDX_SAT = 4'(KW_MAXLEN + 1);

    logic [LEN_W-1:0] r_len, n_len;
    logic             r_ended, n_ended;
    logic             r_in_field, n_in_field;
    logic [FC_W-1:0]  r_fcount, n_fcount;
    t_kw_vec          r_flags, n_flags;
    logic [3:0]       r_idx, n_idx;
    t_num_phase       r_phase, n_phase;
    logic [14:0]      r_acc, n_acc;
    logic             r_half, n_half;
    t_kw_vec          r_m0, r_m1, r_m2, n_m0, n_m1, n_m2;
    logic             r_num_ok, n_num_ok;
    logic [15:0]      r_num, n_num;

    t_kw_vec          w_cur_match;
    logic             w_cur_num_ok;
    logic [15:0]      w_cur_num;
    logic [FC_W-1:0]  w_fc_inc;
    logic             w_sep;
    logic             w_start;
    t_kw_vec          w_base_flags;
    logic [3:0]       w_base_idx;
    t_num_phase       w_base_phase;
    logic [14:0]      w_base_acc;
    logic             w_base_half;
    logic [7:0]       w_up;
    logic [18:0]      w_acc_calc;
    logic             w_digit;

    always_comb begin
        for (int k = 0; k < KW_COUNT; k++) begin
            w_cur_match[k] = r_flags[k] && (r_idx == KW_LEN[k]);
        end
        w_cur_num_ok = (r_phase == NUM_INT) || (r_phase == NUM_FRAC);
        w_cur_num    = {r_acc, r_half};
        w_fc_inc     = (r_fcount == FC_W'(MAX_FIELDS + 1)) ? r_fcount : r_fcount + 1'b1;
        w_sep        = (i_text_byte == CHR_SPACE) || (i_text_byte == CHR_TAB);
        w_start      = !r_in_field;
        w_base_flags = w_start ? '1 : r_flags;
        w_base_idx   = w_start ? 4'd0 : r_idx;
        w_base_phase = w_start ? NUM_NODIGIT : r_phase;
        w_base_acc   = w_start ? 15'd0 : r_acc;
        w_base_half  = w_start ? 1'b0 : r_half;
        w_up         = to_upper(i_text_byte);
        w_digit      = (i_text_byte >= CHR_ZERO) && (i_text_byte <= CHR_NINE);
        w_acc_calc   = ({4'b0, w_base_acc} << 3) + ({4'b0, w_base_acc} << 1)
                     + {11'b0, i_text_byte - CHR_ZERO};
    end

    always_comb begin
        n_len      = r_len;
        n_ended    = r_ended;
        n_in_field = r_in_field;
        n_fcount   = r_fcount;
        n_flags    = r_flags;
        n_idx      = r_idx;
        n_phase    = r_phase;
        n_acc      = r_acc;
        n_half     = r_half;
        n_m0       = r_m0;
        n_m1       = r_m1;
        n_m2       = r_m2;
        n_num_ok   = r_num_ok;
        n_num      = r_num;
        if (i_accept && i_line_end) begin
            n_len      = '0;
            n_ended    = 1'b0;
            n_in_field = 1'b0;
            n_fcount   = '0;
        end else if (i_accept && !r_ended) begin
            if (i_text_byte == 8'd0) begin
                n_ended = 1'b1;
            end else begin
                if (r_len != LEN_W'(LINE_CAPACITY)) begin
                    n_len = r_len + 1'b1;
                end
                if (w_sep) begin
                    if (r_in_field) begin
                        n_in_field = 1'b0;
                        n_fcount   = w_fc_inc;
                        if (r_fcount == FC_W'(0)) begin
                            n_m0 = w_cur_match;
                        end
                        if (r_fcount == FC_W'(1)) begin
                            n_m1 = w_cur_match;
                        end
                        if (r_fcount == FC_W'(2)) begin
                            n_m2     = w_cur_match;
                            n_num_ok = w_cur_num_ok;
                            n_num    = w_cur_num;
                        end
                    end
                end else begin
                    n_in_field = 1'b1;
                    for (int k = 0; k < KW_COUNT; k++) begin
                        n_flags[k] = w_base_flags[k] && kw_hit(k, w_base_idx, w_up);
                    end
                    n_idx  = (w_base_idx == IDX_SAT) ? w_base_idx : w_base_idx + 1'b1;
                    n_acc  = w_base_acc;
                    n_half = w_base_half;
                    case (w_base_phase)
                        NUM_NODIGIT, NUM_INT: begin
                            if (w_digit) begin
                                if (w_acc_calc > 19'(NUM_INT_MAX)) begin
                                    n_phase = NUM_BAD;
                                end else begin
                                    n_phase = NUM_INT;
                                    n_acc   = w_acc_calc[14:0];
                                end
                            end else if ((w_base_phase == NUM_INT) &&
                                         (i_text_byte == CHR_DOT)) begin
                                n_phase = NUM_DOT;
                            end else begin
                                n_phase = NUM_BAD;
                            end
                        end
                        NUM_DOT: begin
                            if (i_text_byte == CHR_FIVE) begin
                                n_phase = NUM_FRAC;
                                n_half  = 1'b1;
                            end else if (i_text_byte == CHR_ZERO) begin
                                n_phase = NUM_FRAC;
                            end else begin
                                n_phase = NUM_BAD;
                            end
                        end
                        default: begin
                            n_phase = NUM_BAD;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len      <= '0;
            r_ended    <= 1'b0;
            r_in_field <= 1'b0;
            r_fcount   <= '0;
        end else begin
            r_len      <= n_len;
            r_ended    <= n_ended;
            r_in_field <= n_in_field;
            r_fcount   <= n_fcount;
        end
    end

    always_ff @(posedge i_clk) begin
        r_flags  <= n_flags;
        r_idx    <= n_idx;
        r_phase  <= n_phase;
        r_acc    <= n_acc;
        r_half   <= n_half;
        r_m0     <= n_m0;
        r_m1     <= n_m1;
        r_m2     <= n_m2;
        r_num_ok <= n_num_ok;
        r_num    <= n_num;
    end

    always_comb begin
        o_sum.too_long = (r_len == LEN_W'(LINE_CAPACITY));
        o_sum.nfields  = 4'(r_in_field ? w_fc_inc : r_fcount);
        o_sum.match0   = (r_in_field && (r_fcount == FC_W'(0))) ? w_cur_match : r_m0;
        o_sum.match1   = (r_in_field && (r_fcount == FC_W'(1))) ? w_cur_match : r_m1;
        o_sum.match2   = (r_in_field && (r_fcount == FC_W'(2))) ? w_cur_match : r_m2;
        o_sum.num_ok   = (r_in_field && (r_fcount == FC_W'(2))) ? w_cur_num_ok : r_num_ok;
        o_sum.num      = (r_in_field && (r_fcount == FC_W'(2))) ? w_cur_num : r_num;
    end

endmodule

`default_nettype wire

[rtl/core/tcld_decode.sv]
// Line-end command decode from the scanner's line summary.
// Depends on tcld_pkg; the result is registered by the top level.
`timescale 1ns / 1ps
`default_nettype none

module tcld_decode
    import tcld_pkg::*;
#(
    parameter int MAX_FIELDS = MAX_FIELDS_DEF
) (
    input  wire t_line_sum   i_sum,
    input  wire logic [7:0]  i_att_max,
    output t_result          o_res
);

    logic       w_mask_ok;
    logic [1:0] w_mask;
    logic       w_sw_ok1, w_sw_ok2;
    logic       w_att_ok;
    logic       w_ph_ok;
    logic [3:0] w_ph_code;

    always_comb begin
        w_mask_ok = i_sum.match1[KW_ONE] || i_sum.match1[KW_TWO] || i_sum.match1[KW_ALL];
        w_mask    = i_sum.match1[KW_ALL] ? 2'd3 : (i_sum.match1[KW_TWO] ? 2'd2 : 2'd1);
        w_sw_ok1  = i_sum.match1[KW_ON] || i_sum.match1[KW_OFF];
        w_sw_ok2  = i_sum.match2[KW_ON] || i_sum.match2[KW_OFF];
        w_att_ok  = i_sum.num_ok && (i_sum.num <= {8'b0, i_att_max});
        w_ph_ok   = 1'b0;
        w_ph_code = 4'd0;
        for (int k = 0; k < PHASE_CODES; k++) begin
            if (i_sum.num == 16'(k * PHASE_STEP)) begin
                w_ph_ok   = i_sum.num_ok;
                w_ph_code = 4'(k);
            end
        end
    end

    always_comb begin
        o_res = '{command: CMD_NONE, error_code: ERR_OK, chan_sel: 2'd0,
                  amount: 8'd0, switch_on: 1'b0};
        if (i_sum.too_long) begin
            o_res.error_code = ERR_TOO_LONG;
        end else if (i_sum.nfields == 4'd0) begin
            o_res.error_code = ERR_EMPTY;
        end else if (i_sum.nfields > 4'(MAX_FIELDS)) begin
            o_res.error_code = ERR_SYNTAX;
        end else if ((i_sum.nfields == 4'd1) && i_sum.match0[KW_PING]) begin
            o_res.command = CMD_PING;
        end else if ((i_sum.nfields == 4'd1) && i_sum.match0[KW_KEEPALIVE]) begin
            o_res.command = CMD_KEEPALIVE;
        end else if ((i_sum.nfields == 4'd1) && i_sum.match0[KW_HELP]) begin
            o_res.command = CMD_HELP;
        end else if ((i_sum.nfields == 4'd1) && i_sum.match0[KW_STATUS]) begin
            o_res.command = CMD_STATUS;
        end else if ((i_sum.nfields == 4'd1) && i_sum.match0[KW_SAFE]) begin
            o_res.command = CMD_SAFE;
        end else if ((i_sum.nfields == 4'd2) && i_sum.match0[KW_FAULT] &&
                     i_sum.match1[KW_CLEAR]) begin
            o_res.command = CMD_FAULT_CLR;
        end else if ((i_sum.nfields == 4'd2) && i_sum.match0[KW_POWER] && w_sw_ok1) begin
            o_res.command   = CMD_POWER;
            o_res.switch_on = i_sum.match1[KW_ON];
        end else if ((i_sum.nfields == 4'd3) && i_sum.match0[KW_POWER] &&
                     i_sum.match1[KW_EXTERNAL] && w_sw_ok2) begin
            o_res.command   = CMD_POWER_EXT;
            o_res.switch_on = i_sum.match2[KW_ON];
        end else if ((i_sum.nfields == 4'd3) && i_sum.match0[KW_ATT]) begin
            if (!w_mask_ok) begin
                o_res.error_code = ERR_SYNTAX;
            end else if (!w_att_ok) begin
                o_res.error_code = ERR_RANGE;
            end else begin
                o_res.command  = CMD_ATT;
                o_res.chan_sel = w_mask;
                o_res.amount   = i_sum.num[7:0];
            end
        end else if ((i_sum.nfields == 4'd3) && i_sum.match0[KW_PHASE]) begin
            if (!w_mask_ok) begin
                o_res.error_code = ERR_SYNTAX;
            end else if (!w_ph_ok) begin
                o_res.error_code = ERR_RANGE;
            end else begin
                o_res.command  = CMD_PHASE;
                o_res.chan_sel = w_mask;
                o_res.amount   = {4'b0, w_ph_code};
            end
        end else if ((i_sum.nfields == 4'd3) && i_sum.match0[KW_LNA] &&
                     w_mask_ok && w_sw_ok2) begin
            o_res.command   = CMD_LNA;
            o_res.chan_sel  = w_mask;
            o_res.switch_on = i_sum.match2[KW_ON];
        end else begin
            o_res.error_code = ERR_SYNTAX;
        end
    end

endmodule

`default_nettype wire

[rtl/core/text_command_line_decoder.sv]
// Top level of the text command line decoder: channels, register port, result register.
// Depends on tcld_pkg, tcld_ifs, tcld_scan and tcld_decode.
//
// Usage: the input channel carries one character per item; an item with
// line_end set closes the line. Each line end yields exactly one item on
// the output channel with the decoded command and an error code; other
// items yield nothing. A zero byte ends the line content early.
// The result of a line is registered when its line-end item is accepted.
// Throughput: one item per cycle while the input is not stalled; every
// character is folded into the registered scan state, and the line-end
// decode is a short combinational path in front of the result register.
// A result that arrives while the previous one still waits is held in a
// spare register. The input stalls only while that spare register is full
// and is released the cycle after the receiver takes the waiting result.
// The attenuation limit is written through the APB port at address zero.
// Synchronous reset clears the line state, drops any pending result and
// sets the attenuation limit to 63 half-unit steps.
`timescale 1ns / 1ps
`default_nettype none

module text_command_line_decoder
    import tcld_pkg::*;
#(
    parameter int LINE_CAPACITY = LINE_CAPACITY_DEF,
    parameter int MAX_FIELDS    = MAX_FIELDS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    tcld_in_if.sink          i_cmd_in,
    tcld_out_if.source       o_cmd_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    logic       r_out_valid, n_out_valid;
    logic       r_spare_valid, n_spare_valid;
    t_result    r_res, n_res;
    t_result    r_spare, n_spare;
    t_result    w_res;
    logic [7:0] r_att_max;
    logic       w_accept;
    logic       w_new;
    logic       w_take;
    logic       w_cfg_wr;
    t_line_sum  w_sum;

    assign i_cmd_in.ready = !r_spare_valid;
    assign w_accept       = i_cmd_in.valid && i_cmd_in.ready;
    assign w_new          = w_accept && i_cmd_in.line_end;
    assign w_take         = r_out_valid && o_cmd_out.ready;
    assign pready         = 1'b1;
    assign w_cfg_wr       = psel && penable && pwrite && (paddr == REG_ATT_MAX[1:0]);
    assign prdata         = (paddr == REG_ATT_MAX[1:0]) ? {24'b0, r_att_max} : 32'd0;

    tcld_scan #(
        .LINE_CAPACITY(LINE_CAPACITY),
        .MAX_FIELDS(MAX_FIELDS)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_text_byte(i_cmd_in.text_byte),
        .i_line_end (i_cmd_in.line_end),
        .o_sum      (w_sum)
    );

    tcld_decode #(
        .MAX_FIELDS(MAX_FIELDS)
    ) u_decode (
        .i_sum    (w_sum),
        .i_att_max(r_att_max),
        .o_res    (w_res)
    );

    always_comb begin
        n_out_valid   = r_out_valid;
        n_spare_valid = r_spare_valid;
        n_res         = r_res;
        n_spare       = r_spare;
        if (w_take) begin
            if (r_spare_valid) begin
                n_res         = r_spare;
                n_spare_valid = 1'b0;
            end else begin
                n_out_valid = w_new;
                if (w_new) begin
                    n_res = w_res;
                end
            end
        end else if (!r_out_valid) begin
            n_out_valid = w_new;
            if (w_new) begin
                n_res = w_res;
            end
        end else if (w_new) begin
            n_spare       = w_res;
            n_spare_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid   <= 1'b0;
            r_spare_valid <= 1'b0;
            r_att_max     <= 8'(ATT_MAX_RESET);
        end else begin
            r_out_valid   <= n_out_valid;
            r_spare_valid <= n_spare_valid;
            if (w_cfg_wr) begin
                r_att_max <= pwdata[7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res   <= n_res;
        r_spare <= n_spare;
    end

    assign o_cmd_out.valid      = r_out_valid;
    assign o_cmd_out.command    = r_res.command;
    assign o_cmd_out.error_code = r_res.error_code;
    assign o_cmd_out.chan_sel   = r_res.chan_sel;
    assign o_cmd_out.amount     = r_res.amount;
    assign o_cmd_out.switch_on  = r_res.switch_on;

    a_result_follows_line_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_cmd_in.line_end) |=> r_out_valid)
        else $error("line end did not produce a result");

    a_error_has_no_command: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_res.error_code != ERR_OK)) |-> (r_res.command == CMD_NONE))
        else $error("error result carries a command");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_cmd_in.ready)
        else $error("input stalled with empty result register");

endmodule

`default_nettype wire
